// ===== src/video_register_port_vram_assert.svh =====
// Assertion macros used by the checker file vrp_checker.sv.
`ifndef VIDEO_REGISTER_PORT_VRAM_ASSERT_SVH
`define VIDEO_REGISTER_PORT_VRAM_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define VRP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("video register port check failed");

// Next-cycle implication, off while reset is high.
`define VRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("video register port check failed");

`endif

// ===== src/vrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared constants, request codes, types and the video address map.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int NT_BYTES  = 4096;
  localparam int NT_AW     = $clog2(NT_BYTES);
  localparam int PAL_BYTES = 32;
  localparam int PAL_AW    = $clog2(PAL_BYTES);

  localparam logic [7:0] UNMAPPED_BYTE = 8'hAA;
  localparam logic [7:0] VBLANK_SET    = 8'b1000_0000;
  localparam logic [7:0] VBLANK_CLR    = 8'b0111_1111;
  localparam logic [7:0] STRIDE_BIT    = 8'b0000_0100;

  typedef enum logic [3:0] {
    REQ_WR_CTRL    = 4'd0,
    REQ_WR_MASK    = 4'd1,
    REQ_RD_STATUS  = 4'd2,
    REQ_WR_OAMADDR = 4'd3,
    REQ_WR_OAMDATA = 4'd4,
    REQ_RD_OAMDATA = 4'd5,
    REQ_WR_SCROLL  = 4'd6,
    REQ_WR_ADDR    = 4'd7,
    REQ_RD_DATA    = 4'd8,
    REQ_WR_DATA    = 4'd9,
    REQ_FRAME_DONE = 4'd10
  } req_e;

  typedef struct packed {
    logic             hit;
    logic             pal;
    logic [NT_AW-1:0] idx;
  } vmap_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             pal;
    logic [NT_AW-1:0] idx;
    logic [7:0]       wdata;
  } mem_req_t;

  // Nametable at 0x2000-0x2FFF and mirror at 0x3000-0x3EFF, palette at
  // 0x3F00-0x3FFF wrapping every 32 bytes; everything else is unmapped.
  function automatic vmap_t vram_map(input logic [15:0] a);
    vmap_t m;
    m.hit = 1'b0;
    m.pal = 1'b0;
    m.idx = a[NT_AW-1:0];
    if (a[15:12] == 4'h2) begin
      m.hit = 1'b1;
    end else if (a[15:8] == 8'h3F) begin
      m.hit = 1'b1;
      m.pal = 1'b1;
      m.idx = {{(NT_AW-PAL_AW){1'b0}}, a[PAL_AW-1:0]};
    end else if (a[15:12] == 4'h3) begin
      m.hit = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== src/vrp_vram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_vram
// Nametable and palette memories, single port, registered read, with a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module vrp_vram (
  input  logic              clk,
  input  logic              rst,
  input  vrp_pkg::mem_req_t req,
  output logic [7:0]        rdata,
  output logic              ready
);

  logic [7:0] nt_mem  [vrp_pkg::NT_BYTES];
  logic [7:0] pal_mem [vrp_pkg::PAL_BYTES];

  logic                     clearing;
  logic [vrp_pkg::NT_AW-1:0] clr_cnt;
  logic [7:0]               nt_q;
  logic [7:0]               pal_q;
  logic                     pal_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == vrp_pkg::NT_AW'(vrp_pkg::NT_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      nt_mem[clr_cnt] <= '0;
    end else if (req.wr_en && !req.pal) begin
      nt_mem[req.idx] <= req.wdata;
    end
    if (req.rd_en) begin
      nt_q <= nt_mem[req.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      pal_mem[clr_cnt[vrp_pkg::PAL_AW-1:0]] <= '0;
    end else if (req.wr_en && req.pal) begin
      pal_mem[req.idx[vrp_pkg::PAL_AW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      pal_q   <= pal_mem[req.idx[vrp_pkg::PAL_AW-1:0]];
      pal_sel <= req.pal;
    end
  end

  assign rdata = pal_sel ? pal_q : nt_q;
  assign ready = !clearing;

endmodule

// ===== src/video_register_port_vram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_register_port_vram
// Processor-side video register port with nametable and palette memory.
// ----------------------------------------------------------------------------
// Channel   Ports                                      Handshake
// request   req_type, wdata                            start & !busy
// result    rdata, vblank, nmi_enabled,                done, one cycle
//           greyscale, bg_enable
//
// The accept cycle performs register updates and the memory access, the next
// cycle waits on the registered memory read; done rises in the cycle after
// that, and a new transaction may be accepted in that same cycle. After reset
// is released, busy stays high while the memories are zeroed one entry per
// cycle. The receiver cannot stall; results are presented once.
// ----------------------------------------------------------------------------
module video_register_port_vram (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] req_type,
  input  logic [7:0] wdata,
  output logic       done,
  output logic [7:0] rdata,
  output logic       vblank,
  output logic       nmi_enabled,
  output logic       greyscale,
  output logic       bg_enable
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } state_t;

  state_t state;

  logic [7:0]  ctrl_reg;
  logic [7:0]  mask_reg;
  logic [7:0]  status_reg;
  logic [7:0]  sprite_addr_reg;
  logic [7:0]  sprite_data_reg;
  logic [7:0]  scroll_reg;
  logic [15:0] video_addr;
  logic [15:0] video_addr_next;
  logic [7:0]  resp_byte;
  logic [7:0]  resp_byte_next;
  logic        resp_mem;
  logic        resp_mem_next;

  logic              accept;
  vrp_pkg::vmap_t    vmap;
  vrp_pkg::mem_req_t mreq;
  logic [7:0]        mem_rdata;
  logic              mem_ready;

  assign accept = (state == ST_IDLE) && start;
  assign busy   = (state != ST_IDLE);
  assign vmap   = vrp_pkg::vram_map(video_addr);

  assign video_addr_next = video_addr +
                           (((ctrl_reg & vrp_pkg::STRIDE_BIT) != 8'd0) ? 16'd32 : 16'd1);

  always_comb begin
    mreq.rd_en = accept && (req_type == vrp_pkg::REQ_RD_DATA) && vmap.hit;
    mreq.wr_en = accept && (req_type == vrp_pkg::REQ_WR_DATA) && vmap.hit;
    mreq.pal   = vmap.pal;
    mreq.idx   = vmap.idx;
    mreq.wdata = wdata;
  end

  always_comb begin
    resp_mem_next  = 1'b0;
    resp_byte_next = 8'd0;
    unique case (req_type)
      vrp_pkg::REQ_RD_STATUS:  resp_byte_next = status_reg;
      vrp_pkg::REQ_RD_OAMDATA: resp_byte_next = sprite_data_reg;
      vrp_pkg::REQ_RD_DATA: begin
        resp_mem_next  = vmap.hit;
        resp_byte_next = vrp_pkg::UNMAPPED_BYTE;
      end
      default: ;
    endcase
  end

  vrp_vram u_vram (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (mem_rdata),
    .ready (mem_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      done            <= 1'b0;
      ctrl_reg        <= '0;
      mask_reg        <= '0;
      status_reg      <= '0;
      sprite_addr_reg <= '0;
      sprite_data_reg <= '0;
      scroll_reg      <= '0;
      video_addr      <= '0;
    end else begin
      done <= (state == ST_RESP);
      unique case (state)
        ST_CLEAR: begin
          if (mem_ready) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state     <= ST_RESP;
            resp_mem  <= resp_mem_next;
            resp_byte <= resp_byte_next;
            unique case (req_type)
              vrp_pkg::REQ_WR_CTRL:    ctrl_reg        <= wdata;
              vrp_pkg::REQ_WR_MASK:    mask_reg        <= wdata;
              vrp_pkg::REQ_RD_STATUS:  status_reg      <= status_reg & vrp_pkg::VBLANK_CLR;
              vrp_pkg::REQ_WR_OAMADDR: sprite_addr_reg <= wdata;
              vrp_pkg::REQ_WR_OAMDATA: sprite_data_reg <= wdata;
              vrp_pkg::REQ_WR_SCROLL:  scroll_reg      <= wdata;
              vrp_pkg::REQ_WR_ADDR:    video_addr      <= {video_addr[7:0], wdata};
              vrp_pkg::REQ_RD_DATA:    video_addr      <= video_addr_next;
              vrp_pkg::REQ_WR_DATA:    video_addr      <= video_addr_next;
              vrp_pkg::REQ_FRAME_DONE: status_reg      <= status_reg | vrp_pkg::VBLANK_SET;
              default: ;
            endcase
          end
        end
        ST_RESP: begin
          // present the transaction result from the settled registers
          state       <= ST_IDLE;
          rdata       <= resp_mem ? mem_rdata : resp_byte;
          vblank      <= status_reg[7];
          nmi_enabled <= ctrl_reg[7];
          greyscale   <= mask_reg[0];
          bg_enable   <= mask_reg[3] ^ (sprite_addr_reg[0] & scroll_reg[0] & 1'b0);
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

endmodule

// ===== src/vrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level checks on transaction timing of the video register port.
// ----------------------------------------------------------------------------
`include "video_register_port_vram_assert.svh"

module vrp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `VRP_ASSERT_NEXT(a_accept_then_busy, clk, rst, start && !busy, busy)
  `VRP_ASSERT_NEXT(a_accept_then_done, clk, rst, start && !busy, !done ##1 done)
  `VRP_ASSERT_SAME(a_done_when_free, clk, rst, done, !busy)
  `VRP_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

bind video_register_port_vram vrp_checker u_vrp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== bench/video_register_port_vram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_register_port_vram_tb
// Checks the video register port against a cycle-free model of its registers,
// nametable and palette. Each accepted request is applied to the model and the
// predicted result is queued. Every done strobe is compared field by field
// with the oldest queued result. Stimulus is a directed pass over the address
// map and special cases, then random address/data bursts, read-backs, vblank
// traffic, register writes and noise, with random gaps on the request side.
// ----------------------------------------------------------------------------
module video_register_port_vram_tb;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 8;
  localparam int MAX_PRINTS    = 60;

  // Request codes the block does not decode
  localparam logic [3:0] REQ_UNUSED_LO = 4'd11;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [7:0] rdata;
    logic       vblank;
    logic       nmi;
    logic       grey;
    logic       bg;
  } port_result_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [3:0] req_type;
  logic [7:0] wdata;
  logic       done;
  logic [7:0] rdata;
  logic       vblank;
  logic       nmi_enabled;
  logic       greyscale;
  logic       bg_enable;

  video_register_port_vram dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .wdata       (wdata),
    .done        (done),
    .rdata       (rdata),
    .vblank      (vblank),
    .nmi_enabled (nmi_enabled),
    .greyscale   (greyscale),
    .bg_enable   (bg_enable)
  );

  // Model state
  logic [7:0]  ctrl_q;
  logic [7:0]  mask_q;
  logic [7:0]  status_q;
  logic [7:0]  oam_addr_q;
  logic [7:0]  oam_data_q;
  logic [7:0]  scroll_q;
  logic [15:0] vaddr_q;
  logic [7:0]  nametable_q [vrp_pkg::NT_BYTES];
  logic [7:0]  palette_q [vrp_pkg::PAL_BYTES];

  port_result_t pending_results [$];
  port_result_t want;
  logic [15:0]  written_addrs [$];

  int  error_count;
  int  sent_count;
  int  result_count;
  int  data_read_count;
  int  vblank_read_count;
  int  cycle_count;
  bit  quiet;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("video_register_port_vram_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, exp_val, $time);
  endtask

  // Locate a video address in nametable or palette; 0 for pattern/unmapped.
  function automatic bit locate_vram(input logic [15:0] a, output bit is_pal,
                                     output int idx);
    is_pal = 1'b0;
    idx    = 0;
    if (a >= 16'h2000 && a <= 16'h2FFF) begin
      idx = a - 16'h2000;
      return 1'b1;
    end
    if (a >= 16'h3000 && a <= 16'h3EFF) begin
      idx = a - 16'h3000;
      return 1'b1;
    end
    if (a >= 16'h3F00) begin
      if (a <= 16'h3FFF) begin
        is_pal = 1'b1;
        idx    = (a - 16'h3F00) % vrp_pkg::PAL_BYTES;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic port_result_t predict_access(input logic [3:0] code,
                                                  input logic [7:0] wd);
    port_result_t r;
    bit           is_pal;
    int           idx;
    r = '0;
    case (code)
      vrp_pkg::REQ_WR_CTRL:    ctrl_q = wd;
      vrp_pkg::REQ_WR_MASK:    mask_q = wd;
      vrp_pkg::REQ_RD_STATUS: begin
        r.rdata  = status_q;
        status_q = status_q & vrp_pkg::VBLANK_CLR;
      end
      vrp_pkg::REQ_WR_OAMADDR: oam_addr_q = wd;
      vrp_pkg::REQ_WR_OAMDATA: oam_data_q = wd;
      vrp_pkg::REQ_RD_OAMDATA: r.rdata = oam_data_q;
      vrp_pkg::REQ_WR_SCROLL:  scroll_q = wd;
      vrp_pkg::REQ_WR_ADDR:    vaddr_q = {vaddr_q[7:0], wd};
      vrp_pkg::REQ_RD_DATA: begin
        if (locate_vram(vaddr_q, is_pal, idx))
          r.rdata = is_pal ? palette_q[idx] : nametable_q[idx];
        else
          r.rdata = vrp_pkg::UNMAPPED_BYTE;
        vaddr_q = vaddr_q + (((ctrl_q & vrp_pkg::STRIDE_BIT) != 0) ? 16'd32 : 16'd1);
      end
      vrp_pkg::REQ_WR_DATA: begin
        if (locate_vram(vaddr_q, is_pal, idx)) begin
          if (is_pal)
            palette_q[idx] = wd;
          else
            nametable_q[idx] = wd;
        end
        vaddr_q = vaddr_q + (((ctrl_q & vrp_pkg::STRIDE_BIT) != 0) ? 16'd32 : 16'd1);
      end
      vrp_pkg::REQ_FRAME_DONE: status_q = status_q | vrp_pkg::VBLANK_SET;
      default: ;
    endcase
    r.vblank = status_q[7];
    r.nmi    = ctrl_q[7];
    r.grey   = mask_q[0];
    r.bg     = mask_q[3];
    return r;
  endfunction

  // Issue one transaction and wait for the accepting edge; start stays high.
  task automatic send_access(input logic [3:0] code, input logic [7:0] wd);
    int gap;
    gap = 0;
    if (!quiet)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= code;
    wdata    <= wd;
    do @(posedge clk); while (busy);
    if (code == vrp_pkg::REQ_RD_DATA) data_read_count++;
    if (code == vrp_pkg::REQ_RD_STATUS && status_q[7]) vblank_read_count++;
    if (code == vrp_pkg::REQ_WR_DATA) begin
      written_addrs.push_back(vaddr_q);
      if (written_addrs.size() > 16) void'(written_addrs.pop_front());
    end
    pending_results.push_back(predict_access(code, wd));
    sent_count++;
  endtask

  task automatic set_vaddr(input logic [15:0] a);
    send_access(vrp_pkg::REQ_WR_ADDR, a[15:8]);
    send_access(vrp_pkg::REQ_WR_ADDR, a[7:0]);
  endtask

  // Hold off requests until every pending result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", rdata, 0);
      end else begin
        want = pending_results.pop_front();
        result_count++;
        if (rdata !== want.rdata)        report_mismatch("rdata", rdata, want.rdata);
        if (vblank !== want.vblank)      report_mismatch("vblank", vblank, want.vblank);
        if (nmi_enabled !== want.nmi)    report_mismatch("nmi_enabled", nmi_enabled, want.nmi);
        if (greyscale !== want.grey)     report_mismatch("greyscale", greyscale, want.grey);
        if (bg_enable !== want.bg)       report_mismatch("bg_enable", bg_enable, want.bg);
      end
    end
  end

  task automatic test_registers();
    send_access(vrp_pkg::REQ_RD_STATUS, 8'h00);
    send_access(vrp_pkg::REQ_FRAME_DONE, 8'h00);
    send_access(vrp_pkg::REQ_RD_STATUS, 8'hFF);   // returns vblank, then clears it
    send_access(vrp_pkg::REQ_WR_CTRL, 8'hFF);
    send_access(vrp_pkg::REQ_WR_MASK, 8'hFF);
    send_access(vrp_pkg::REQ_WR_OAMDATA, 8'hFF);
    send_access(vrp_pkg::REQ_RD_OAMDATA, 8'h00);
    send_access(vrp_pkg::REQ_WR_OAMADDR, 8'hFF);
    send_access(vrp_pkg::REQ_WR_SCROLL, 8'hFF);
    send_access(REQ_UNUSED_HI, 8'hFF);            // undecoded: no state change
    send_access(vrp_pkg::REQ_WR_CTRL, vrp_pkg::STRIDE_BIT);
    send_access(vrp_pkg::REQ_WR_MASK, 8'h00);
  endtask

  task automatic test_vram_map();
    set_vaddr(16'h3FE5);                          // palette mirror wraps to entry 5
    send_access(vrp_pkg::REQ_WR_DATA, 8'h5A);
    send_access(vrp_pkg::REQ_RD_DATA, 8'h00);     // stride 32 lands in unmapped space
    set_vaddr(16'h3123);                          // nametable mirror
    send_access(vrp_pkg::REQ_WR_DATA, 8'hC3);
    set_vaddr(16'hFFF0);
    send_access(vrp_pkg::REQ_RD_DATA, 8'h00);     // address wraps past 0xFFFF
    send_access(vrp_pkg::REQ_WR_CTRL, 8'h00);
    set_vaddr(16'h2123);
    send_access(vrp_pkg::REQ_RD_DATA, 8'h00);
  endtask

  function automatic logic [7:0] pick_high_byte();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'h20 + 8'($urandom_range(15));
      4, 5:       return 8'h30 + 8'($urandom_range(14));
      6, 7:       return 8'h3F;
      8:          return 8'($urandom_range(8'h1F));
      default:    return 8'($urandom_range(8'hFF, 8'h40));
    endcase
  endfunction

  task automatic test_random();
    int          base;
    int          burst;
    logic [15:0] a;
    logic [7:0]  lo;
    bit          paused;
    base   = sent_count;
    paused = 1'b0;
    while (sent_count - base < RANDOM_ITEMS) begin
      quiet = (sent_count - base >= 700) && (sent_count - base < 1100);
      if (!paused && sent_count - base >= 1200) begin
        drain_results();
        paused = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:34]: begin
          lo = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                        : 8'($urandom_range(255));
          if ($urandom_range(3) == 0)
            send_access(vrp_pkg::REQ_WR_CTRL, 8'($urandom_range(255)));
          set_vaddr({pick_high_byte(), lo});
          burst = $urandom_range(8, 1);
          repeat (burst) begin
            if ($urandom_range(1))
              send_access(vrp_pkg::REQ_WR_DATA, 8'($urandom_range(255)));
            else
              send_access(vrp_pkg::REQ_RD_DATA, 8'($urandom_range(255)));
          end
        end
        [35:49]: begin
          if (written_addrs.size() != 0)
            a = written_addrs[$urandom_range(written_addrs.size() - 1)];
          else
            a = {pick_high_byte(), 8'($urandom_range(255))};
          set_vaddr(a);
          send_access(vrp_pkg::REQ_RD_DATA, 8'($urandom_range(255)));
        end
        [50:64]: begin
          if ($urandom_range(1))
            send_access(vrp_pkg::REQ_FRAME_DONE, 8'($urandom_range(255)));
          send_access(vrp_pkg::REQ_RD_STATUS, 8'($urandom_range(255)));
        end
        [65:79]: begin
          case ($urandom_range(4))
            0: send_access(vrp_pkg::REQ_WR_CTRL, 8'($urandom_range(255)));
            1: send_access(vrp_pkg::REQ_WR_MASK, 8'($urandom_range(255)));
            2: send_access(vrp_pkg::REQ_WR_OAMADDR, 8'($urandom_range(255)));
            3: send_access(vrp_pkg::REQ_WR_SCROLL, 8'($urandom_range(255)));
            default: begin
              send_access(vrp_pkg::REQ_WR_OAMDATA, 8'($urandom_range(255)));
              send_access(vrp_pkg::REQ_RD_OAMDATA, 8'($urandom_range(255)));
            end
          endcase
        end
        [80:89]: begin
          if ($urandom_range(2) == 0)
            send_access(4'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)),
                        8'($urandom_range(255)));
          else
            send_access(4'($urandom_range(15)), 8'($urandom_range(255)));
        end
        default: begin
          // broken address sequences: lone or extra address bytes
          repeat ($urandom_range(3, 1))
            send_access(vrp_pkg::REQ_WR_ADDR, 8'($urandom_range(255)));
          send_access($urandom_range(1) ? vrp_pkg::REQ_RD_DATA : vrp_pkg::REQ_WR_DATA,
                      8'($urandom_range(255)));
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  initial begin
    ctrl_q     = '0;
    mask_q     = '0;
    status_q   = '0;
    oam_addr_q = '0;
    oam_data_q = '0;
    scroll_q   = '0;
    vaddr_q    = '0;
    foreach (nametable_q[i]) nametable_q[i] = '0;
    foreach (palette_q[i]) palette_q[i] = '0;
    error_count       = 0;
    sent_count        = 0;
    result_count      = 0;
    data_read_count   = 0;
    vblank_read_count = 0;
    cycle_count       = 0;
    quiet             = 1'b0;

    rst      <= 1'b1;
    start    <= 1'b0;
    req_type <= vrp_pkg::REQ_WR_CTRL;
    wdata    <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_registers();
    test_vram_map();
    drain_results();
    test_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d transactions, %0d results checked", sent_count, result_count);
    $display("video data reads %0d, status reads seeing vblank %0d",
             data_read_count, vblank_read_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("video_register_port_vram_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_results.size());
      $display("video_register_port_vram_tb: done, errors");
    end
    $finish;
  end

endmodule
